// ===== rtl/mima_pkg.sv =====
`default_nettype none
package mima_pkg;

    localparam logic [7:0] MIDI_SOX = 8'hF0;
    localparam logic [7:0] MIDI_EOX = 8'hF7;
    localparam logic [3:0] MIDI_SYS_NIB = 4'hF;
    localparam logic [3:0] MIDI_PGM_NIB = 4'hC;
    localparam logic [3:0] MIDI_CHP_NIB = 4'hD;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [15:0] SYSEX_LEN_RST = 16'd256;

    typedef enum logic [1:0] {
        CFG_PORT_MASK  = 2'd0,
        CFG_START_TIME = 2'd1,
        CFG_SYSEX_LEN  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_SHORT = 1'b0,
        KIND_SYSEX = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0]  rs;
        logic [23:0] msg;
        logic [1:0]  cnt;
        logic        excl;
        logic [15:0] fill;
    } t_port_state;

    typedef struct packed {
        logic [1:0]  port;
        t_kind       kind;
        logic [23:0] message;
        logic [15:0] byte_index;
        logic        done;
        logic [31:0] timestamp;
    } t_entry;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage
`default_nettype wire

// ===== rtl/mima_in_if.sv =====
`default_nettype none
interface mima_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  port;
    logic [7:0]  data_byte;
    logic [31:0] timestamp;
    logic        buffer_queued;

    modport source (output valid, output port, output data_byte, output timestamp,
                    output buffer_queued, input ready);
    modport sink (input valid, input port, input data_byte, input timestamp,
                  input buffer_queued, output ready);
endinterface
`default_nettype wire

// ===== rtl/mima_out_if.sv =====
`default_nettype none
interface mima_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_port;
    logic        event_kind;
    logic [23:0] message;
    logic [15:0] byte_index;
    logic        buffer_done;
    logic [31:0] event_time;

    modport source (output valid, output out_port, output event_kind, output message,
                    output byte_index, output buffer_done, output event_time, input ready);
    modport sink (input valid, input out_port, input event_kind, input message,
                  input byte_index, input buffer_done, input event_time, output ready);
endinterface
`default_nettype wire

// ===== rtl/mima_front.sv =====
`default_nettype none
module mima_front #(
    parameter int NUM_PORTS = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    mima_in_if.sink              i_in,
    input  wire [3:0]            i_port_mask,
    input  wire [15:0]           i_sysex_len,
    input  mima_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output mima_pkg::t_entry     o_entry
);
    import mima_pkg::*;

    t_port_state r_st [NUM_PORTS];
    t_port_state w_cur;
    t_port_state n_st;
    t_entry      w_entry;
    logic        w_emit;
    logic        w_acc;
    logic        w_en;

    assign i_in.ready = !i_q_status.full;
    assign w_acc = i_in.valid && i_in.ready;
    assign w_en = ({30'd0, i_in.port} < 32'(NUM_PORTS)) && i_port_mask[i_in.port];

    always_comb begin
        w_cur = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if ({30'd0, i_in.port} == 32'(i)) begin
                w_cur = r_st[i];
            end
        end
    end

    // per-port byte parser
    always_comb begin
        logic [16:0] nf;
        logic [15:0] pos;
        logic        done;
        logic        drop;
        logic [1:0]  cnt;
        logic [7:0]  b0;
        logic [1:0]  need;
        n_st = w_cur;
        w_emit = 1'b0;
        w_entry = '0;
        w_entry.port = i_in.port;
        w_entry.timestamp = i_in.timestamp;
        pos = w_cur.fill;
        nf = {1'b0, w_cur.fill} + 17'd1;
        done = 1'b0;
        drop = 1'b0;
        cnt = 2'd0;
        b0 = 8'd0;
        need = 2'd0;
        if (w_cur.excl) begin
            if (i_in.buffer_queued) begin
                if (nf >= {1'b0, i_sysex_len}) begin
                    done = 1'b1;
                end
                n_st.fill = nf[15:0];
            end
            if (i_in.data_byte == MIDI_EOX) begin
                n_st.excl = 1'b0;
                done = 1'b1;
            end
            if (i_in.buffer_queued) begin
                if (done) begin
                    n_st.fill = '0;
                end
                w_emit = 1'b1;
                w_entry.kind = KIND_SYSEX;
                w_entry.message = {16'd0, i_in.data_byte};
                w_entry.byte_index = pos;
                w_entry.done = done;
            end
        end else begin
            if (i_in.data_byte[7]) begin
                n_st.cnt = 2'd0;
                n_st.msg = '0;
            end else if (w_cur.cnt == 2'd0) begin
                if (w_cur.rs[7] && (w_cur.rs[7:4] != MIDI_SYS_NIB)) begin
                    n_st.msg = {16'd0, w_cur.rs};
                    n_st.cnt = 2'd1;
                end else begin
                    drop = 1'b1;
                end
            end
            if (!drop) begin
                cnt = n_st.cnt;
                case (cnt)
                    2'd0: n_st.msg[7:0] = i_in.data_byte;
                    2'd1: n_st.msg[15:8] = i_in.data_byte;
                    2'd2: n_st.msg[23:16] = i_in.data_byte;
                    default: ;
                endcase
                if (cnt != 2'd3) begin
                    cnt = cnt + 2'd1;
                end
                n_st.cnt = cnt;
                b0 = n_st.msg[7:0];
                if ((cnt == 2'd1) && (b0[7:4] != MIDI_SYS_NIB)) begin
                    n_st.rs = b0;
                end
                if (b0[7:4] == MIDI_SYS_NIB) begin
                    if (b0 == MIDI_SOX) begin
                        n_st.excl = 1'b1;
                        n_st.cnt = 2'd0;
                    end else begin
                        need = 2'd1;
                    end
                end else if ((b0[7:4] == MIDI_PGM_NIB) || (b0[7:4] == MIDI_CHP_NIB)) begin
                    need = 2'd2;
                end else if (b0[7]) begin
                    need = 2'd3;
                end
                if ((need != 2'd0) && (cnt == need)) begin
                    n_st.cnt = 2'd0;
                    w_emit = 1'b1;
                    w_entry.kind = KIND_SHORT;
                    w_entry.message = n_st.msg;
                    n_st.msg = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_st[i] <= '0;
            end
        end else if (w_acc && w_en) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                if ({30'd0, i_in.port} == 32'(i)) begin
                    r_st[i] <= n_st;
                end
            end
        end
    end

    assign o_push = w_acc && w_en && w_emit;
    assign o_entry = w_entry;
endmodule
`default_nettype wire

// ===== rtl/mima_queue.sv =====
`default_nettype none
module mima_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  mima_pkg::t_entry     i_wdata,
    input  wire                  i_pop,
    output mima_pkg::t_q_status  o_status,
    output mima_pkg::t_entry     o_rdata
);
    import mima_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_status.full = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_status.valid = (r_cnt != '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop = i_pop && o_status.valid;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10: r_cnt <= r_cnt + 1'b1;
                2'b01: r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mima_back.sv =====
`default_nettype none
module mima_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mima_pkg::t_q_status  i_q_status,
    input  mima_pkg::t_entry     i_entry,
    input  wire [31:0]           i_start_time,
    output logic                 o_pop,
    mima_out_if.source           o_out
);
    import mima_pkg::*;

    logic        r_valid;
    logic [1:0]  r_port;
    t_kind       r_kind;
    logic [23:0] r_message;
    logic [15:0] r_index;
    logic        r_done;
    logic [31:0] r_time;
    logic [31:0] n_time;

    assign o_pop = i_q_status.valid && (!r_valid || o_out.ready);

    // short messages are stamped relative to the start tick
    assign n_time = (i_entry.kind == KIND_SHORT) ? (i_entry.timestamp - i_start_time)
                                                 : i_entry.timestamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_port <= i_entry.port;
            r_kind <= i_entry.kind;
            r_message <= i_entry.message;
            r_index <= i_entry.byte_index;
            r_done <= i_entry.done;
            r_time <= n_time;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.out_port = r_port;
    assign o_out.event_kind = r_kind;
    assign o_out.message = r_message;
    assign o_out.byte_index = r_index;
    assign o_out.buffer_done = r_done;
    assign o_out.event_time = r_time;
endmodule
`default_nettype wire

// ===== rtl/midi_input_message_assembler.sv =====
// path: a beat that completes a result is written into the queue at the accepting edge
// and moved from there into the output register, where it is held until it is taken
// throughput: one beat per cycle; a four-entry queue between parser and output register
// absorbs output stalls, input ready drops only when that queue is full
// reset: synchronous, active low; clears all per-port parser state and the queue,
// port mask and start time to zero, exclusive buffer length to 256
`default_nettype none
module midi_input_message_assembler #(
    parameter int NUM_PORTS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mima_in_if.sink     i_in,
    mima_out_if.source  o_out,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_idx,
    input  wire [31:0]  i_cfg_data
);
    import mima_pkg::*;

    logic [3:0]  r_port_mask;
    logic [31:0] r_start_time;
    logic [15:0] r_sysex_len;
    t_q_status   w_q_status;
    t_entry      w_push_entry;
    t_entry      w_pop_entry;
    logic        w_push;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_mask <= '0;
            r_start_time <= '0;
            r_sysex_len <= SYSEX_LEN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PORT_MASK:  r_port_mask <= i_cfg_data[3:0];
                CFG_START_TIME: r_start_time <= i_cfg_data;
                CFG_SYSEX_LEN:  r_sysex_len <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mima_front #(
        .NUM_PORTS (NUM_PORTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_port_mask (r_port_mask),
        .i_sysex_len (r_sysex_len),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    mima_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_push_entry),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_rdata  (w_pop_entry)
    );

    mima_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_entry      (w_pop_entry),
        .i_start_time (r_start_time),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

`ifndef SYNTH
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_q_status.valid)
        else $error("input stalled with empty queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_sysex_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_kind == KIND_SYSEX)) |-> (o_out.message[23:8] == '0))
        else $error("exclusive beat carries more than one byte");

    a_short_no_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_kind == KIND_SHORT))
        |-> ((o_out.byte_index == '0) && !o_out.buffer_done))
        else $error("short message with buffer fields set");
`endif
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    import mima_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0]  port;
        logic [7:0]  data;
        logic [31:0] stamp;
        logic        queued;
    } t_midi_beat;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    t_cfg_idx cfg_idx;
    logic [31:0] cfg_data;

    mima_in_if in_bus();
    mima_out_if out_bus();

    midi_input_message_assembler #(.NUM_PORTS(4)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_bus),
        .o_out(out_bus),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // per-port parser state mirrored from the block
    logic [3:0]  port_mask;
    logic [31:0] start_stamp;
    logic [15:0] sysex_len;
    logic [7:0]  run_status [4];
    logic [23:0] part_msg [4];
    logic [1:0]  part_cnt [4];
    logic        sx_active [4];
    logic [15:0] sx_fill [4];

    t_midi_beat beats_to_send [$];
    t_entry expected_events [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    bit in_taken = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int beats_in = 0;
    int shorts_seen = 0;
    int sysex_seen = 0;
    int buffers_done = 0;

    function automatic void reset_parser();
        port_mask = '0;
        start_stamp = '0;
        sysex_len = SYSEX_LEN_RST;
        for (int i = 0; i < 4; i++) begin
            run_status[i] = '0;
            part_msg[i] = '0;
            part_cnt[i] = '0;
            sx_active[i] = 1'b0;
            sx_fill[i] = '0;
        end
    endfunction

    function automatic bit assemble_event(input logic [1:0] p, input logic [7:0] b,
                                          input logic [31:0] ts, input logic q,
                                          output t_entry ev);
        logic        done;
        logic [15:0] pos;
        logic [16:0] nf;
        logic [7:0]  b0;
        int          c;
        int          need;
        ev = '0;
        if (!port_mask[p]) return 1'b0;
        if (sx_active[p]) begin
            done = 1'b0;
            pos = sx_fill[p];
            if (q) begin
                nf = {1'b0, pos} + 17'd1;
                if (nf >= {1'b0, sysex_len}) done = 1'b1;
                sx_fill[p] = nf[15:0];
            end
            if (b == MIDI_EOX) begin
                sx_active[p] = 1'b0;
                done = 1'b1;
            end
            if (!q) return 1'b0;
            if (done) sx_fill[p] = '0;
            ev.port = p;
            ev.kind = KIND_SYSEX;
            ev.message = {16'h0, b};
            ev.byte_index = pos;
            ev.done = done;
            ev.timestamp = ts;
            return 1'b1;
        end
        if (b[7]) begin
            part_cnt[p] = '0;
            part_msg[p] = '0;
        end else if (part_cnt[p] == 2'd0) begin
            if (run_status[p][7] && run_status[p][7:4] != MIDI_SYS_NIB) begin
                part_msg[p] = {16'h0, run_status[p]};
                part_cnt[p] = 2'd1;
            end else begin
                return 1'b0;
            end
        end
        c = part_cnt[p];
        if (c < 3) begin
            part_msg[p][8*c +: 8] = b;
            c++;
        end
        part_cnt[p] = c[1:0];
        b0 = part_msg[p][7:0];
        if (c == 1 && b0[7:4] != MIDI_SYS_NIB) run_status[p] = b0;
        if (b0[7:4] == MIDI_SYS_NIB) begin
            if (b0 == MIDI_SOX) begin
                sx_active[p] = 1'b1;
                part_cnt[p] = '0;
                return 1'b0;
            end
            need = 1;
        end else if (b0[7:4] == MIDI_PGM_NIB || b0[7:4] == MIDI_CHP_NIB) begin
            need = 2;
        end else if (b0[7]) begin
            need = 3;
        end else begin
            return 1'b0;
        end
        if (c != need) return 1'b0;
        part_cnt[p] = '0;
        ev.port = p;
        ev.kind = KIND_SHORT;
        ev.message = part_msg[p];
        ev.timestamp = ts - start_stamp;
        part_msg[p] = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(19))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_beat(input logic [1:0] p, input logic [7:0] b,
                                       input logic q, input logic [31:0] ts);
        t_midi_beat beat;
        beat.port = p;
        beat.data = b;
        beat.queued = q;
        beat.stamp = ts;
        beats_to_send.push_back(beat);
    endfunction

    function automatic void queue_data(input logic [1:0] p);
        queue_beat(p, 8'($urandom_range(127)), 1'($urandom), pick_stamp());
    endfunction

    // one random phrase: mostly well-formed messages, some broken ones and noise
    function automatic int queue_phrase();
        logic [1:0] p;
        logic [7:0] st;
        int pick;
        int n;
        int start_size;
        start_size = beats_to_send.size();
        p = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 35) begin
            st = 8'h80 + 8'($urandom_range(8'h6F));
            queue_beat(p, st, 1'($urandom), pick_stamp());
            queue_data(p);
            if (st[7:4] != MIDI_PGM_NIB && st[7:4] != MIDI_CHP_NIB) queue_data(p);
        end else if (pick < 55) begin
            n = $urandom_range(1, 4);
            repeat (n) queue_data(p);
        end else if (pick < 65) begin
            queue_beat(p, 8'hF1 + 8'($urandom_range(14)), 1'($urandom), pick_stamp());
        end else if (pick < 80) begin
            queue_beat(p, MIDI_SOX, 1'b1, pick_stamp());
            n = $urandom_range(0, 12);
            repeat (n) begin
                if ($urandom_range(9) == 0) st = 8'($urandom);
                else st = 8'($urandom_range(127));
                queue_beat(p, st, $urandom_range(99) < 85, pick_stamp());
            end
            if ($urandom_range(99) < 85)
                queue_beat(p, MIDI_EOX, $urandom_range(99) < 85, pick_stamp());
        end else if (pick < 90) begin
            queue_beat(p, 8'h80 + 8'($urandom_range(8'h3F)), 1'($urandom), pick_stamp());
            if ($urandom_range(1)) queue_data(p);
        end else begin
            queue_beat(p, 8'($urandom), 1'($urandom), pick_stamp());
        end
        return beats_to_send.size() - start_size;
    endfunction

    function automatic void queue_directed();
        queue_beat(2'd0, 8'h90, 1'b1, 32'h0);
        queue_beat(2'd0, 8'h3C, 1'b1, 32'h0);
        queue_beat(2'd0, 8'h7F, 1'b1, 32'h0);
        // running status
        queue_beat(2'd0, 8'h00, 1'b0, 32'hFFFF_FFFF);
        queue_beat(2'd0, 8'h7F, 1'b0, 32'hFFFF_FFFF);
        queue_beat(2'd0, 8'hC5, 1'b1, 32'h1234_5678);
        queue_beat(2'd0, 8'h7F, 1'b1, 32'h1234_5678);
        queue_beat(2'd0, 8'hD0, 1'b0, 32'h8000_0000);
        queue_beat(2'd0, 8'h00, 1'b0, 32'h8000_0000);
        // status restarts a partial message
        queue_beat(2'd0, 8'h80, 1'b1, 32'h10);
        queue_beat(2'd0, 8'h3C, 1'b1, 32'h11);
        queue_beat(2'd0, 8'hB0, 1'b1, 32'h12);
        queue_beat(2'd0, 8'h07, 1'b1, 32'h13);
        queue_beat(2'd0, 8'h64, 1'b1, 32'h14);
        // data with no running status, system common and realtime
        queue_beat(2'd1, 8'h40, 1'b1, 32'h20);
        queue_beat(2'd1, 8'hF1, 1'b1, 32'h21);
        queue_beat(2'd1, 8'h05, 1'b1, 32'h22);
        queue_beat(2'd1, 8'hFF, 1'b0, 32'h23);
        queue_beat(2'd1, MIDI_EOX, 1'b1, 32'h24);
        // exclusive filling a short buffer, then closed by end of exclusive
        queue_beat(2'd2, MIDI_SOX, 1'b1, 32'h30);
        for (int i = 1; i <= 4; i++) queue_beat(2'd2, 8'(i), 1'b1, 32'h30 + i);
        queue_beat(2'd2, MIDI_EOX, 1'b1, 32'h35);
        // exclusive with no host buffer queued
        queue_beat(2'd3, MIDI_SOX, 1'b1, 32'hFFFF_FFFF);
        queue_beat(2'd3, 8'h7F, 1'b0, 32'hFFFF_FFFF);
        queue_beat(2'd3, MIDI_EOX, 1'b0, 32'hFFFF_FFFF);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        do @(posedge i_clk);
        while (beats_to_send.size() != 0 || in_bus.valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random phase with a full drain halfway through
    task automatic run_phase(input int beats, input int idle_pct, input int stall_pct);
        int queued_now;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            queued_now = 0;
            while (queued_now < beats / 2) queued_now += queue_phrase();
            drain_all();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // beat driver
    always @(negedge i_clk) begin
        t_midi_beat beat;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                beat = beats_to_send.pop_front();
                in_bus.valid <= 1'b1;
                in_bus.port <= beat.port;
                in_bus.data_byte <= beat.data;
                in_bus.timestamp <= beat.stamp;
                in_bus.buffer_queued <= beat.queued;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_entry ev;
        bit fire_in;
        bit fire_out;
        fire_in = (in_bus.valid === 1'b1) && (in_bus.ready === 1'b1);
        fire_out = (out_bus.valid === 1'b1) && (out_bus.ready === 1'b1);
        if (!i_rst_n) begin
            reset_parser();
            in_taken = 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken = fire_in;
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_PORT_MASK: port_mask = cfg_data[3:0];
                    CFG_START_TIME: start_stamp = cfg_data;
                    CFG_SYSEX_LEN: sysex_len = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (fire_in) begin
                beats_in++;
                if (assemble_event(in_bus.port, in_bus.data_byte, in_bus.timestamp,
                                   in_bus.buffer_queued, ev))
                    expected_events.push_back(ev);
            end
            if (fire_out) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result beat: port %0d kind %0d message %0h",
                           out_bus.out_port, out_bus.event_kind, out_bus.message);
                    mismatches++;
                end else begin
                    ev = expected_events.pop_front();
                    check_field("out_port", 32'(ev.port), 32'(out_bus.out_port));
                    check_field("event_kind", 32'(ev.kind), 32'(out_bus.event_kind));
                    check_field("message", 32'(ev.message), 32'(out_bus.message));
                    check_field("byte_index", 32'(ev.byte_index), 32'(out_bus.byte_index));
                    check_field("buffer_done", 32'(ev.done), 32'(out_bus.buffer_done));
                    check_field("event_time", ev.timestamp, out_bus.event_time);
                    if (ev.kind == KIND_SHORT) shorts_seen++;
                    else sysex_seen++;
                    if (ev.done) buffers_done++;
                end
            end
            if (fire_in || fire_out || cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_PORT_MASK;
        cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.port = '0;
        in_bus.data_byte = '0;
        in_bus.timestamp = '0;
        in_bus.buffer_queued = 1'b0;
        out_bus.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all ports stopped after reset
        queue_beat(2'd0, 8'hF8, 1'b1, 32'h1);
        queue_beat(2'd3, MIDI_SOX, 1'b1, 32'h2);
        drain_all();
        write_reg(CFG_PORT_MASK, 32'h0);
        queue_beat(2'd1, 8'hFE, 1'b1, 32'h3);
        drain_all();

        // default buffer length and start time
        write_reg(CFG_PORT_MASK, 32'hF);
        run_phase(300, 0, 0);

        write_reg(CFG_START_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_SYSEX_LEN, 32'd3);
        queue_directed();
        drain_all();

        write_reg(CFG_PORT_MASK, 32'hB);
        write_reg(CFG_START_TIME, $urandom);
        write_reg(CFG_SYSEX_LEN, 32'd1);
        run_phase(400, 56, 0);

        write_reg(CFG_PORT_MASK, 32'hF);
        write_reg(CFG_START_TIME, $urandom);
        write_reg(CFG_SYSEX_LEN, 32'd65535);
        run_phase(400, 0, 56);

        write_reg(CFG_PORT_MASK, 32'h7);
        write_reg(CFG_START_TIME, 32'h0);
        write_reg(CFG_SYSEX_LEN, 32'd8);
        run_phase(400, 38, 38);

        // receiver holds off while the sender keeps offering beats
        write_reg(CFG_PORT_MASK, 32'hF);
        write_reg(CFG_SYSEX_LEN, 32'd5);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req++;
        repeat (60) queue_beat(2'($urandom_range(3)), 8'hF8, 1'($urandom), pick_stamp());
        drain_all();

        $display("run covered %0d input beats: %0d short messages, %0d exclusive bytes",
                 beats_in, shorts_seen, sysex_seen);
        $display("%0d exclusive buffers handed back, %0d field mismatches",
                 buffers_done, mismatches);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/mima_pkg.sv
rtl/mima_in_if.sv
rtl/mima_out_if.sv
rtl/mima_front.sv
rtl/mima_queue.sv
rtl/mima_back.sv
rtl/midi_input_message_assembler.sv
test/tb_top.sv
